/* design/falm_pkg.sv */
// Package for find_all_literal_matches: result type, register indexes,
// ASCII constants and byte helpers. Depends on nothing.
`timescale 1ns / 1ps

package falm_pkg;

	localparam int REG_W   = 64;
	localparam int POS_W   = 32;
	localparam int INDEX_W = 3;

	typedef enum logic [INDEX_W-1:0] {
		REG_NEEDLE_LOW  = 3'd0,
		REG_NEEDLE_HIGH = 3'd1,
		REG_NEEDLE_LEN  = 3'd2,
		REG_MATCH_CASE  = 3'd3,
		REG_WHOLE_WORD  = 3'd4
	} reg_index_t;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_LOWER_A    = 8'h61;
	localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
	localparam logic [7:0] CH_UPPER_A    = 8'h41;
	localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
	localparam logic [7:0] CH_DIGIT_0    = 8'h30;
	localparam logic [7:0] CH_DIGIT_9    = 8'h39;
	localparam logic [7:0] CASE_OFFSET   = 8'h20;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	typedef struct packed {
		logic [POS_W-1:0] match_end;
		logic [POS_W-1:0] match_start;
		logic             last_of_run;
	} result_t;

	function automatic logic is_word_byte(input logic [7:0] c);
		logic w;
		w = (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
			(c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || (c == CH_UNDERSCORE);
		return w;
	endfunction

	// exact = 1 leaves the byte alone, else upper case folds to lower
	function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
		logic [7:0] f;
		f = c;
		if (!exact && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			f = c + CASE_OFFSET;
		end
		return f;
	endfunction

endpackage

/* design/find_all_literal_matches.sv */
// find_all_literal_matches: streaming literal search over a byte text.
// Depends on falm_pkg for the result type, register indexes and byte helpers.
//
// channel   signals                               items
// s_        s_tvalid s_tready s_tdata s_tlast     text byte, end of text on tlast
// m_        m_tvalid m_tready m_tdata m_tlast     match, last result of a byte on tlast
// cfg_      cfg_wr_en cfg_index cfg_data          register write, no read-back
//
// One text byte per cycle: the window compare runs on the byte in the input
// register, and up to two results go into a four-entry output queue. A byte
// moves on only while the queue has room for two results, so the queue drain
// of one result per cycle sets the rate when bytes give two matches.
// arst_n clears the text state, the queue and the registers (needle empty).
// A stalled m_tready fills the queue and then holds s_tready low.
`timescale 1ns / 1ps

module find_all_literal_matches #(
	parameter int MAX_NEEDLE = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] text_byte
	input  logic                        s_tlast,   // end_of_text
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [2*falm_pkg::POS_W-1:0] m_tdata,  // [31:0] match_start, [63:32] match_end
	output logic                        m_tlast,   // last_of_run
	input  logic                        cfg_wr_en,
	input  logic [falm_pkg::INDEX_W-1:0] cfg_index,
	input  logic [falm_pkg::REG_W-1:0]  cfg_data
);

	localparam int HIST  = MAX_NEEDLE + 1;
	localparam int WIN_N = HIST + 1;
	localparam int WIN_W = $clog2(WIN_N);
	localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
	localparam int QD    = 4;
	localparam int QP_W  = $clog2(QD);
	localparam int QC_W  = $clog2(QD + 1);
	localparam int PW    = falm_pkg::POS_W;

	// configuration
	logic [2*falm_pkg::REG_W-1:0] needle_q;
	logic [4:0]                   needle_len_q;
	logic                         match_case_q;
	logic                         whole_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q     <= '0;
			needle_len_q <= '0;
			match_case_q <= 1'b0;
			whole_word_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				falm_pkg::REG_NEEDLE_LOW:  needle_q[falm_pkg::REG_W-1:0] <= cfg_data;
				falm_pkg::REG_NEEDLE_HIGH: needle_q[2*falm_pkg::REG_W-1:falm_pkg::REG_W] <= cfg_data;
				falm_pkg::REG_NEEDLE_LEN:  needle_len_q <= cfg_data[4:0];
				falm_pkg::REG_MATCH_CASE:  match_case_q <= cfg_data[0];
				falm_pkg::REG_WHOLE_WORD:  whole_word_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       move_s1;

	logic [QC_W-1:0] count_q;
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	falm_pkg::result_t queue_q [QD];

	assign move_s1  = valid_s1 && (count_q <= QC_W'(QD - 2));
	assign s_tready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	// text state
	logic [7:0]    hist_q [HIST];
	logic [PW-1:0] bytes_seen_q;
	logic [PW-1:0] next_start_q;

	// window: entry k is the byte k positions before the current one
	logic [7:0]       win [WIN_N];
	logic [7:0]       fwin [WIN_N];
	logic [7:0]       fneedle [MAX_NEEDLE];
	logic [LEN_W-1:0] len;
	logic [WIN_W-1:0] len_w;
	logic             body1, body2;
	logic             ok1, ok2;
	logic             live;
	logic [PW-1:0]    p, e2, s1, s2, next_after1;

	always_comb begin
		win[0] = byte_s1;
		for (int k = 1; k < WIN_N; k++) begin
			win[k] = hist_q[k-1];
		end
		for (int k = 0; k < WIN_N; k++) begin
			fwin[k] = falm_pkg::fold(win[k], match_case_q);
		end
		for (int j = 0; j < MAX_NEEDLE; j++) begin
			fneedle[j] = falm_pkg::fold(needle_q[j*8 +: 8], match_case_q);
		end
	end

	always_comb begin
		if (needle_len_q > 5'(MAX_NEEDLE)) begin
			len = LEN_W'(MAX_NEEDLE);
		end else begin
			len = needle_len_q[LEN_W-1:0];
		end
		len_w = WIN_W'(len);
		// candidate ending before this byte and candidate ending with it
		body1 = 1'b1;
		body2 = 1'b1;
		for (int j = 0; j < MAX_NEEDLE; j++) begin
			if (LEN_W'(j) < len) begin
				if (fwin[len_w - WIN_W'(j)] != fneedle[j]) begin
					body1 = 1'b0;
				end
				if (fwin[len_w - WIN_W'(j) - WIN_W'(1)] != fneedle[j]) begin
					body2 = 1'b0;
				end
			end
		end
	end

	always_comb begin
		p    = bytes_seen_q;
		e2   = p + PW'(1);
		s1   = p - PW'(len);
		s2   = e2 - PW'(len);
		live = (bytes_seen_q != falm_pkg::POS_MAX) && (len != '0);

		ok1 = live && (p >= PW'(len)) && (s1 >= next_start_q) && body1;
		if (whole_word_q) begin
			if ((s1 != '0) && falm_pkg::is_word_byte(win[len_w + WIN_W'(1)])) begin
				ok1 = 1'b0;
			end
			if (falm_pkg::is_word_byte(win[0])) begin
				ok1 = 1'b0;
			end
		end
		next_after1 = ok1 ? p : next_start_q;

		ok2 = live && eot_s1 && (e2 >= PW'(len)) && (s2 >= next_after1) && body2;
		if (whole_word_q && (s2 != '0) && falm_pkg::is_word_byte(win[len_w])) begin
			ok2 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HIST; k++) begin
				hist_q[k] <= '0;
			end
			bytes_seen_q <= '0;
			next_start_q <= '0;
		end else if (move_s1) begin
			if (eot_s1) begin
				for (int k = 0; k < HIST; k++) begin
					hist_q[k] <= '0;
				end
				bytes_seen_q <= '0;
				next_start_q <= '0;
			end else begin
				hist_q[0] <= byte_s1;
				for (int k = 1; k < HIST; k++) begin
					hist_q[k] <= hist_q[k-1];
				end
				if (bytes_seen_q != falm_pkg::POS_MAX) begin
					bytes_seen_q <= bytes_seen_q + PW'(1);
				end
				next_start_q <= ok2 ? e2 : next_after1;
			end
		end
	end

	// output queue
	falm_pkg::result_t r1, r2, first;
	logic       push1, push2, pop;
	logic [1:0] n_push;

	always_comb begin
		r1.match_start = s1;
		r1.match_end   = p;
		r1.last_of_run = !ok2;
		r2.match_start = s2;
		r2.match_end   = e2;
		r2.last_of_run = 1'b1;
		first  = ok1 ? r1 : r2;
		push1  = move_s1 && (ok1 || ok2);
		push2  = move_s1 && ok1 && ok2;
		n_push = {1'b0, push1} + {1'b0, push2};
		pop    = m_tvalid && m_tready;
	end

	always_ff @(posedge clk) begin
		if (push1) begin
			queue_q[wr_ptr_q] <= first;
		end
		if (push2) begin
			queue_q[wr_ptr_q + QP_W'(1)] <= r2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			count_q  <= count_q + QC_W'(n_push) - QC_W'(pop);
			wr_ptr_q <= wr_ptr_q + QP_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			end
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {queue_q[rd_ptr_q].match_end, queue_q[rd_ptr_q].match_start};
	assign m_tlast  = queue_q[rd_ptr_q].last_of_run;

endmodule
